FILE: sv/octant_line_rasterizer_unit_assert.svh
// Assertion macros used by the rasterizer RTL.
`ifndef OCTANT_LINE_RASTERIZER_UNIT_ASSERT_SVH
`define OCTANT_LINE_RASTERIZER_UNIT_ASSERT_SVH

// Checks an implication on every rising edge outside reset.
`define OLR_ASSERT_IMPLY(label, clock, reset, cond, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
    else $error(msg);

// Checks a condition in the cycle after a trigger, outside reset.
`define OLR_ASSERT_NEXT(label, clock, reset, cond, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
    else $error(msg);

`endif

FILE: sv/olr_pkg.sv
`default_nettype none

package olr_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAME_W    = COORD_BITS + 1;
  localparam int EAST_W     = COORD_BITS + 2;
  localparam int DEC_W      = COORD_BITS + 3;
  localparam int IN_DATA_W  = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * COORD_BITS + 7) / 8) * 8;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef enum logic [2:0] {
    OCT_0 = 3'd0,
    OCT_1 = 3'd1,
    OCT_2 = 3'd2,
    OCT_3 = 3'd3,
    OCT_4 = 3'd4,
    OCT_5 = 3'd5,
    OCT_6 = 3'd6,
    OCT_7 = 3'd7
  } octant_t;

  typedef struct packed {
    logic signed [FRAME_W-1:0] walk_major;
    logic signed [FRAME_W-1:0] walk_minor;
    logic signed [FRAME_W-1:0] major_limit;
    logic signed [DEC_W-1:0]   decision_value;
    logic signed [EAST_W-1:0]  step_east;
    logic signed [DEC_W-1:0]   step_northeast;
    octant_t                   octant_code;
  } line_setup_t;

endpackage

`default_nettype wire

FILE: sv/olr_setup.sv
`default_nettype none

module olr_setup (
  input  logic signed [olr_pkg::COORD_BITS-1:0] start_x,
  input  logic signed [olr_pkg::COORD_BITS-1:0] start_y,
  input  logic signed [olr_pkg::COORD_BITS-1:0] end_x,
  input  logic signed [olr_pkg::COORD_BITS-1:0] end_y,
  output olr_pkg::line_setup_t                  setup
);
  import olr_pkg::*;

  typedef struct packed {
    logic signed [FRAME_W-1:0] a;
    logic signed [FRAME_W-1:0] b;
  } frame_pt_t;

  function automatic frame_pt_t to_frame(octant_t oc, logic signed [FRAME_W-1:0] x,
                                         logic signed [FRAME_W-1:0] y);
    frame_pt_t p;
    unique case (oc)
      OCT_0: begin p.a = x;  p.b = y;  end
      OCT_1: begin p.a = y;  p.b = x;  end
      OCT_2: begin p.a = y;  p.b = -x; end
      OCT_3: begin p.a = -x; p.b = y;  end
      OCT_4: begin p.a = -x; p.b = -y; end
      OCT_5: begin p.a = -y; p.b = -x; end
      OCT_6: begin p.a = -y; p.b = x;  end
      OCT_7: begin p.a = x;  p.b = -y; end
    endcase
    return p;
  endfunction

  logic signed [FRAME_W-1:0] x0, y0, x1, y1;
  logic signed [FRAME_W-1:0] dx, dy;
  logic [FRAME_W-1:0]        mag_x, mag_y;
  octant_t                   oc;
  frame_pt_t                 p0, p1;
  logic signed [FRAME_W-1:0] fdx, fdy;

  always_comb begin
    x0 = FRAME_W'(start_x);
    y0 = FRAME_W'(start_y);
    x1 = FRAME_W'(end_x);
    y1 = FRAME_W'(end_y);
    dx = x1 - x0;
    dy = y1 - y0;
    mag_x = dx[FRAME_W-1] ? $unsigned(-dx) : $unsigned(dx);
    mag_y = dy[FRAME_W-1] ? $unsigned(-dy) : $unsigned(dy);

    if (mag_x >= mag_y) begin
      if (!dx[FRAME_W-1]) oc = dy[FRAME_W-1] ? OCT_7 : OCT_0;
      else oc = dy[FRAME_W-1] ? OCT_4 : OCT_3;
    end else begin
      if (!dx[FRAME_W-1]) oc = dy[FRAME_W-1] ? OCT_6 : OCT_1;
      else oc = dy[FRAME_W-1] ? OCT_5 : OCT_2;
    end

    p0  = to_frame(oc, x0, y0);
    p1  = to_frame(oc, x1, y1);
    fdx = p1.a - p0.a;
    fdy = p1.b - p0.b;

    setup.walk_major     = p0.a;
    setup.walk_minor     = p0.b;
    setup.major_limit    = p1.a;
    setup.decision_value = (DEC_W'(fdy) <<< 1) - DEC_W'(fdx);
    setup.step_east      = EAST_W'(fdy) <<< 1;
    setup.step_northeast = (DEC_W'(fdy) - DEC_W'(fdx)) <<< 1;
    setup.octant_code    = oc;
  end

endmodule

`default_nettype wire

FILE: sv/octant_line_rasterizer_unit.sv
// Midpoint line rasterizer covering all eight octants.
// Requests arrive on the s_axis channel. tuser carries the command: a load
// request (tuser low) takes the two endpoints from tdata and starts a new
// line, replacing any line still in progress; it produces no output. A step
// request (tuser high) emits the next pixel of the current line on m_axis,
// with tlast set on the final endpoint, after which the block goes idle.
// A step request while idle is consumed and produces nothing.
// A pixel appears on m_axis in the cycle after its step request is
// accepted. Throughput is one request per cycle unless a pixel is held;
// the decision-variable update is a single add and compare per clock.
// The output register holds one pixel. s_axis_tready is high when that
// register is empty or being taken in the same cycle, so a stalled receiver
// stops input only while a pixel is waiting.
// Reset (rst, synchronous, active high) clears the output valid and the
// line-active flag; the block then waits for a load request.
`default_nettype none
`include "octant_line_rasterizer_unit_assert.svh"

module octant_line_rasterizer_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // start_x, start_y, end_x, end_y from the lowest bit up
  input  logic [olr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // cmd
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // pixel_x, pixel_y from the lowest bit up
  output logic [olr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // last_pixel
  output logic                           m_axis_tlast
);
  import olr_pkg::*;

  localparam int C = COORD_BITS;

  line_setup_t setup;
  line_setup_t line;
  logic        line_active;

  logic                      in_acc;
  logic                      step_go;
  logic                      last;
  logic signed [FRAME_W-1:0] fx, fy;

  olr_setup u_setup (
    .start_x (s_axis_tdata[C-1:0]),
    .start_y (s_axis_tdata[2*C-1:C]),
    .end_x   (s_axis_tdata[3*C-1:2*C]),
    .end_y   (s_axis_tdata[4*C-1:3*C]),
    .setup   (setup)
  );

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign step_go       = in_acc && (s_axis_tuser == CMD_STEP) && line_active;
  assign last          = line.walk_major >= line.major_limit;

  always_comb begin
    unique case (line.octant_code)
      OCT_0: begin fx = line.walk_major;  fy = line.walk_minor;  end
      OCT_1: begin fx = line.walk_minor;  fy = line.walk_major;  end
      OCT_2: begin fx = -line.walk_minor; fy = line.walk_major;  end
      OCT_3: begin fx = -line.walk_major; fy = line.walk_minor;  end
      OCT_4: begin fx = -line.walk_major; fy = -line.walk_minor; end
      OCT_5: begin fx = -line.walk_minor; fy = -line.walk_major; end
      OCT_6: begin fx = line.walk_minor;  fy = -line.walk_major; end
      OCT_7: begin fx = line.walk_major;  fy = -line.walk_minor; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc && (s_axis_tuser == CMD_LOAD)) begin
      line <= setup;
    end else if (step_go && !last) begin
      if (line.decision_value[DEC_W-1]) begin
        line.decision_value <= line.decision_value + DEC_W'(line.step_east);
      end else begin
        line.walk_minor     <= line.walk_minor + FRAME_W'(1);
        line.decision_value <= line.decision_value + line.step_northeast;
      end
      line.walk_major <= line.walk_major + FRAME_W'(1);
    end

    if (step_go) begin
      m_axis_tdata <= OUT_DATA_W'({fy[C-1:0], fx[C-1:0]});
      m_axis_tlast <= last;
    end

    if (rst) begin
      line_active   <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (in_acc && (s_axis_tuser == CMD_LOAD)) begin
        line_active <= 1'b1;
      end else if (step_go && last) begin
        line_active <= 1'b0;
      end
      if (step_go) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  `OLR_ASSERT_NEXT(a_load_starts, clk, rst, in_acc && (s_axis_tuser == CMD_LOAD), line_active, "load did not start a line")
  `OLR_ASSERT_NEXT(a_last_ends, clk, rst, step_go && last, !line_active, "line still active after last pixel")
  `OLR_ASSERT_NEXT(a_idle_step_silent, clk, rst, in_acc && (s_axis_tuser == CMD_STEP) && !line_active, !m_axis_tvalid, "step while idle produced a pixel")
  `OLR_ASSERT_IMPLY(a_major_bound, clk, rst, line_active, line.walk_major <= line.major_limit, "major coordinate passed the line end")

endmodule

`default_nettype wire

FILE: tb/octant_line_rasterizer_checker.sv
`timescale 1ns / 1ps

module octant_line_rasterizer_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  // start_x, start_y, end_x, end_y from the lowest bit up
  input  logic [olr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // cmd
  input  logic                           s_axis_tuser,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // pixel_x, pixel_y from the lowest bit up
  input  logic [olr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // last_pixel
  input  logic                           m_axis_tlast,
  output int                             mismatches,
  output int                             pending,
  output int                             loads,
  output int                             pixels,
  output int                             line_ends,
  output int                             idle_steps,
  output logic [7:0]                     octants_seen
);
  import olr_pkg::*;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  last;
  } pixel_t;

  pixel_t expected_pixels[$];

  logic signed [FRAME_W-1:0] cur_major;
  logic signed [FRAME_W-1:0] cur_minor;
  logic signed [FRAME_W-1:0] end_major;
  logic signed [DEC_W-1:0]   decision;
  logic signed [EAST_W-1:0]  east_inc;
  logic signed [DEC_W-1:0]   diag_inc;
  octant_t                   octant;
  logic                      walking;

  initial begin
    mismatches   = 0;
    loads        = 0;
    pixels       = 0;
    line_ends    = 0;
    idle_steps   = 0;
    octants_seen = '0;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void to_frame(input octant_t o, input int x, input int y,
                                   output int a, output int b);
    case (o)
      OCT_0: begin a = x;  b = y;  end
      OCT_1: begin a = y;  b = x;  end
      OCT_2: begin a = y;  b = -x; end
      OCT_3: begin a = -x; b = y;  end
      OCT_4: begin a = -x; b = -y; end
      OCT_5: begin a = -y; b = -x; end
      OCT_6: begin a = -y; b = x;  end
      default: begin a = x; b = -y; end
    endcase
  endfunction

  function automatic void from_frame(input octant_t o, input int a, input int b,
                                     output int x, output int y);
    case (o)
      OCT_0: begin x = a;  y = b;  end
      OCT_1: begin x = b;  y = a;  end
      OCT_2: begin x = -b; y = a;  end
      OCT_3: begin x = -a; y = b;  end
      OCT_4: begin x = -a; y = -b; end
      OCT_5: begin x = -b; y = -a; end
      OCT_6: begin x = b;  y = -a; end
      default: begin x = a; y = -b; end
    endcase
  endfunction

  always @(posedge clk) begin
    int x0, y0, x1, y1, dx, dy, mx, my, a0, b0, a1, b1, fdx, fdy, px, py;
    octant_t oc;
    pixel_t want, got;
    if (rst) begin
      expected_pixels.delete();
      cur_major = '0;
      cur_minor = '0;
      end_major = '0;
      decision  = '0;
      east_inc  = '0;
      diag_inc  = '0;
      octant    = OCT_0;
      walking   = 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.x    = m_axis_tdata[COORD_BITS-1:0];
        got.y    = m_axis_tdata[2*COORD_BITS-1:COORD_BITS];
        got.last = m_axis_tlast;
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("pixel (%0d, %0d) with no step request pending",
                                    $signed(got.x), $signed(got.y)));
        end else begin
          want = expected_pixels.pop_front();
          pixels++;
          if (want.last) line_ends++;
          if (got.x != want.x)
            report_mismatch($sformatf("pixel_x got %0d expected %0d",
                                      $signed(got.x), $signed(want.x)));
          if (got.y != want.y)
            report_mismatch($sformatf("pixel_y got %0d expected %0d",
                                      $signed(got.y), $signed(want.y)));
          if (got.last != want.last)
            report_mismatch($sformatf("last_pixel got %0b expected %0b",
                                      got.last, want.last));
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == CMD_LOAD) begin
          x0 = $signed(s_axis_tdata[COORD_BITS-1:0]);
          y0 = $signed(s_axis_tdata[2*COORD_BITS-1:COORD_BITS]);
          x1 = $signed(s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]);
          y1 = $signed(s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS]);
          dx = x1 - x0;
          dy = y1 - y0;
          mx = (dx < 0) ? -dx : dx;
          my = (dy < 0) ? -dy : dy;
          // Equal magnitudes fall to the x-major octants.
          if (mx >= my) begin
            if (dx >= 0) begin
              if (dy >= 0) oc = OCT_0;
              else oc = OCT_7;
            end else begin
              if (dy >= 0) oc = OCT_3;
              else oc = OCT_4;
            end
          end else begin
            if (dx >= 0) begin
              if (dy >= 0) oc = OCT_1;
              else oc = OCT_6;
            end else begin
              if (dy >= 0) oc = OCT_2;
              else oc = OCT_5;
            end
          end
          to_frame(oc, x0, y0, a0, b0);
          to_frame(oc, x1, y1, a1, b1);
          fdx = a1 - a0;
          fdy = b1 - b0;
          cur_major = FRAME_W'(a0);
          cur_minor = FRAME_W'(b0);
          end_major = FRAME_W'(a1);
          decision  = DEC_W'(2 * fdy - fdx);
          east_inc  = EAST_W'(2 * fdy);
          diag_inc  = DEC_W'(2 * (fdy - fdx));
          octant    = oc;
          walking   = 1'b1;
          loads++;
          octants_seen[oc] = 1'b1;
        end else if (walking) begin
          from_frame(octant, int'(cur_major), int'(cur_minor), px, py);
          want.x    = px[COORD_BITS-1:0];
          want.y    = py[COORD_BITS-1:0];
          want.last = (cur_major >= end_major);
          expected_pixels.push_back(want);
          if (want.last) begin
            walking = 1'b0;
          end else begin
            // A decision value of zero takes the diagonal step.
            if (decision < 0) begin
              decision = decision + east_inc;
            end else begin
              cur_minor = cur_minor + FRAME_W'(1);
              decision  = decision + diag_inc;
            end
            cur_major = cur_major + FRAME_W'(1);
          end
        end else begin
          idle_steps++;
        end
      end
    end
    pending <= expected_pixels.size();
  end

endmodule

FILE: tb/octant_line_rasterizer_unit_tb.sv
`timescale 1ns / 1ps

module octant_line_rasterizer_unit_tb;
  import olr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 300;
  localparam int LINE_BUDGET = 1550;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = CMD_LOAD;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  int         mismatches, pending, loads, pixels, line_ends, idle_steps;
  logic [7:0] octants_seen;

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit long_hold_req = 1'b0;
  bit held_once = 1'b0;
  int line_requests = 0;
  int cycle_count = 0;

  octant_line_rasterizer_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  octant_line_rasterizer_checker pixel_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .mismatches    (mismatches),
    .pending       (pending),
    .loads         (loads),
    .pixels        (pixels),
    .line_ends     (line_ends),
    .idle_steps    (idle_steps),
    .octants_seen  (octants_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d pixels outstanding.", cycle_count, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [IN_DATA_W-1:0] pack_ends(input int x0, input int y0,
                                                     input int x1, input int y1);
    return {y1[COORD_BITS-1:0], x1[COORD_BITS-1:0], y0[COORD_BITS-1:0], x0[COORD_BITS-1:0]};
  endfunction

  function automatic logic [IN_DATA_W-1:0] random_payload();
    return IN_DATA_W'({$urandom, $urandom});
  endfunction

  function automatic int random_coord();
    return int'($urandom_range(0, 4095)) - 2048;
  endfunction

  // Offsets a coordinate, mirroring the offset when it would leave the range.
  function automatic int nudge(input int c, input int span);
    int d;
    d = int'($urandom_range(0, 2 * span)) - span;
    if (c + d > 2047 || c + d < -2048) return c - d;
    return c + d;
  endfunction

  task automatic send_req(input logic cmd, input logic [IN_DATA_W-1:0] data);
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= data;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    line_requests++;
  endtask

  task automatic draw(input int x0, input int y0, input int x1, input int y1,
                      input int steps);
    send_req(CMD_LOAD, pack_ends(x0, y0, x1, y1));
    repeat (steps) send_req(CMD_STEP, random_payload());
  endtask

  initial begin
    int stall;
    stall = 0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req <= 1'b0;
      end else if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else if (rx_idle && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        stall = $urandom_range(1, 5) - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    int kind, x0, y0, x1, y1, dx, dy, len, steps;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_req(CMD_STEP, random_payload());
    draw(5, -7, 5, -7, 2);
    draw(-2048, -2048, 2047, 0, 2);
    draw(-2048, -2048, 0, 2047, 2);
    draw(2047, -2048, 0, 2047, 2);
    draw(2047, -2048, -2048, 0, 2);
    draw(2047, 2047, -2048, 0, 2);
    draw(2047, 2047, 0, -2048, 2);
    draw(-2048, 2047, 0, -2048, 2);
    draw(-2048, 2047, 2047, 0, 2);
    draw(-2045, -2045, -2048, -2048, 4);

    line_requests = 0;
    while (line_requests < LINE_BUDGET) begin
      if (line_requests > LINE_BUDGET - 250) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end else begin
        tx_idle = ($urandom_range(0, 7) != 0);
        rx_idle = ($urandom_range(0, 7) != 0);
      end
      if (!held_once && line_requests > 400) begin
        held_once = 1'b1;
        long_hold_req <= 1'b1;
        x0 = nudge(0, 1500);
        y0 = nudge(0, 1500);
        draw(x0, y0, x0 - 60, y0 + 23, 61);
        continue;
      end
      kind = $urandom_range(0, 99);
      x0 = random_coord();
      y0 = random_coord();
      if (kind < 77) begin
        if (kind < 69) begin
          x1 = nudge(x0, 12);
          y1 = nudge(y0, 12);
        end else begin
          x1 = nudge(x0, 100);
          y1 = nudge(y0, 100);
        end
        dx = (x1 > x0) ? x1 - x0 : x0 - x1;
        dy = (y1 > y0) ? y1 - y0 : y0 - y1;
        len = ((dx > dy) ? dx : dy) + 1;
        if ($urandom_range(0, 5) == 0) steps = $urandom_range(0, len);
        else steps = len + $urandom_range(0, 2);
        draw(x0, y0, x1, y1, steps);
      end else if (kind < 90) begin
        draw(x0, y0, random_coord(), random_coord(), $urandom_range(1, 16));
      end else begin
        repeat ($urandom_range(1, 3)) send_req(1'($urandom_range(0, 1)), random_payload());
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Covered %0d line loads and %0d checked pixels (%0d line ends); %0d steps idle.",
             loads, pixels, line_ends, idle_steps);
    $display("Octants loaded: %b; receiver held off once for %0d cycles with input stalled.",
             octants_seen, LONG_HOLD);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/olr_pkg.sv
sv/olr_setup.sv
sv/octant_line_rasterizer_unit.sv
tb/octant_line_rasterizer_checker.sv
tb/octant_line_rasterizer_unit_tb.sv
